// ----- rtl/core/klirs_pkg.sv -----
package klirs_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BADQTY   = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic [63:0]        name_word0;
        logic [63:0]        name_word1;
        logic [63:0]        name_word2;
        logic [39:0]        name_word3;
        logic [63:0]        kind_word0;
        logic [63:0]        kind_word1;
        logic [23:0]        kind_word2;
        logic signed [31:0] amount;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  position;
        logic [4:0]  count_after;
        logic [63:0] found_kind0;
        logic [63:0] found_kind1;
        logic [23:0] found_kind2;
        logic [30:0] found_amount;
    } t_rsp;

    // One stored list entry: whole padded key, whole padded tag, quantity.
    typedef struct packed {
        logic [231:0] key;
        logic [151:0] kind;
        logic [30:0]  amount;
    } t_entry;

endpackage

// ----- rtl/core/keyed_list_insert_remove_search.sv -----
// Keyed list with insert, remove and search over a fixed number of entries.
//
// Command channel: drive i_cmd and raise start; the command is taken at the
// rising edge where start is high and busy is low. busy then stays high until
// the command has finished, and no further command is taken meanwhile.
// Result channel: o_valid is high for exactly one cycle with o_res; that cycle
// is the transfer. The receiver cannot stall, so results are never held back;
// busy falls in the same cycle that o_valid rises, so the next command may be
// taken while its predecessor's result is on the ports.
//
// Every command passes through S_DECIDE. Insert, refused commands and the unused
// action code are answered from there. Search and remove visit the entries from
// position 0 upward through the single entry memory: each visited entry is read
// (registered) in S_SCAN_RD and its key compared in S_SCAN_CMP. A remove then
// closes the gap by reading each later entry in S_SHIFT_RD and writing it back
// one position lower in S_SHIFT_WR.
//
// Reset clears the entry count and the control state only. Entry contents are
// not cleared: only entries below the count are ever read.
module keyed_list_insert_remove_search #(
    parameter int CAPACITY = klirs_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  klirs_pkg::t_req   i_cmd,
    output logic              o_valid,
    output klirs_pkg::t_rsp   o_res
);
    import klirs_pkg::*;

    // Index width for the entry memory and width of the count, which must be
    // able to hold CAPACITY itself.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECIDE   = 6'b000010,
        S_SCAN_RD  = 6'b000100,
        S_SCAN_CMP = 6'b001000,
        S_SHIFT_RD = 6'b010000,
        S_SHIFT_WR = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    t_rsp              r_res, n_res;
    logic              r_valid, n_valid;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;

    // Entry memory: one write port and one read port with registered data.
    t_entry            mem [CAPACITY];
    t_entry            r_rdata;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic [231:0]      req_key;
    logic              key_hit;
    logic              bad_qty;
    logic              next_in_list;
    logic [CNT_W:0]    idx_plus1;
    logic [IDX_W+3:0]  idx_wide;
    logic [CNT_W+3:0]  cnt_wide;
    logic [CNT_W+4:0]  cnt_out_wide;

    assign req_key = {r_req.name_word3, r_req.name_word2, r_req.name_word1,
                      r_req.name_word0};

    // The shared compare unit: the whole padded key against the entry just read.
    assign key_hit = (r_rdata.key == req_key);

    // A quantity must be strictly positive.
    assign bad_qty = (r_req.amount == 32'sd0) || r_req.amount[31];

    // Whether the entry after r_idx still lies inside the list.
    assign idx_plus1    = (CNT_W + 1)'(r_idx) + (CNT_W + 1)'(1);
    assign next_in_list = (idx_plus1 < (CNT_W + 1)'(r_count));

    // Positions and counts are masked to the width of the result fields.
    assign idx_wide     = (IDX_W + 4)'(r_idx);
    assign cnt_wide     = (CNT_W + 4)'(r_count);
    assign cnt_out_wide = (CNT_W + 5)'(n_count);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_res     = r_res;
        n_valid   = 1'b0;
        n_count   = r_count;
        n_idx     = r_idx;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rdata;
        rd_en     = 1'b0;
        rd_addr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_cmd;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res = '0;
                unique case (r_req.action) inside
                    ACT_INSERT: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else if (bad_qty) begin
                            n_res.status = ST_BADQTY;
                        end else begin
                            mem_we           = 1'b1;
                            mem_waddr        = r_count[IDX_W-1:0];
                            mem_wdata.key    = req_key;
                            mem_wdata.kind   = {r_req.kind_word2, r_req.kind_word1,
                                                r_req.kind_word0};
                            mem_wdata.amount = r_req.amount[30:0];
                            n_res.position   = cnt_wide[3:0];
                            n_count          = r_count + CNT_W'(1);
                        end
                    end
                    ACT_REMOVE, ACT_SEARCH: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_valid      = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (key_hit) begin
                    n_res.position = idx_wide[3:0];
                    if (r_req.action == ACT_SEARCH) begin
                        n_res.found_kind0  = r_rdata.kind[63:0];
                        n_res.found_kind1  = r_rdata.kind[127:64];
                        n_res.found_kind2  = r_rdata.kind[151:128];
                        n_res.found_amount = r_rdata.amount;
                        n_valid            = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else if (next_in_list) begin
                    n_idx   = idx_plus1[IDX_W-1:0];
                    n_state = S_SCAN_RD;
                end else begin
                    n_res.status = ST_NOTFOUND;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SHIFT_RD: begin
                if (next_in_list) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_plus1[IDX_W-1:0];
                    n_state = S_SHIFT_WR;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rdata;
                n_idx     = idx_plus1[IDX_W-1:0];
                n_state   = S_SHIFT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.count_after = cnt_out_wide[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // A result is only shown once the sequencer is free again.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while the sequencer is still working");

    // An accepted command always occupies the sequencer in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !r_valid))
        else $error("command accepted without occupying the sequencer");

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // Refused or failed commands report position zero and no found entry.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.status != ST_OK)) |->
            ((r_res.position == 4'd0) && (r_res.found_amount == 31'd0)))
        else $error("failed command reports a position or found entry");

endmodule

// ----- tb/klirs_tb_pkg.sv -----
`timescale 1ns / 1ps
package klirs_tb_pkg;
    import klirs_pkg::*;

    localparam int SHADOW_CAP = CAPACITY_DEF;

    // Shadow copy of the keyed list. Each accepted command is applied to it at once,
    // and the reply it should produce is queued until the block's strobe comes.
    class list_shadow;
        t_entry      held[SHADOW_CAP];
        int unsigned held_count;
        t_rsp        expected_replies[$];
        int unsigned mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        // First entry whose whole padded name equals the key, or -1.
        function int find_name(logic [231:0] name);
            for (int i = 0; i < held_count; i++) begin
                if (held[i].key == name) return i;
            end
            return -1;
        endfunction

        function t_rsp apply_command(t_req c);
            t_rsp         r;
            logic [231:0] name;
            int           idx;
            r    = '0;
            name = {c.name_word3, c.name_word2, c.name_word1, c.name_word0};
            r.status = ST_OK;
            case (c.action)
                ACT_INSERT: begin
                    // A full list is reported before a bad quantity.
                    if (held_count >= SHADOW_CAP) begin
                        r.status = ST_FULL;
                    end else if (c.amount[31] || c.amount == 32'd0) begin
                        r.status = ST_BADQTY;
                    end else begin
                        held[held_count].key    = name;
                        held[held_count].kind   = {c.kind_word2, c.kind_word1, c.kind_word0};
                        held[held_count].amount = c.amount[30:0];
                        r.position = held_count[3:0];
                        held_count++;
                    end
                end
                ACT_REMOVE, ACT_SEARCH: begin
                    idx = (held_count == 0) ? -1 : find_name(name);
                    if (held_count == 0) begin
                        r.status = ST_EMPTY;
                    end else if (idx < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.position = idx[3:0];
                        if (c.action == ACT_REMOVE) begin
                            for (int i = idx; i + 1 < held_count; i++) held[i] = held[i + 1];
                            held_count--;
                        end else begin
                            r.found_kind0  = held[idx].kind[63:0];
                            r.found_kind1  = held[idx].kind[127:64];
                            r.found_kind2  = held[idx].kind[151:128];
                            r.found_amount = held[idx].amount;
                        end
                    end
                end
                default: begin
                    // The unused action code leaves the list alone.
                end
            endcase
            r.count_after = held_count[4:0];
            return r;
        endfunction

        function void note_command(t_req c);
            expected_replies.push_back(apply_command(c));
        endfunction

        function void check_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_replies.size() == 0) begin
                $error("result with no command outstanding, status 0x%0h", got.status);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("position", 64'(want.position), 64'(got.position));
            check_field("count_after", 64'(want.count_after), 64'(got.count_after));
            check_field("found_kind0", want.found_kind0, got.found_kind0);
            check_field("found_kind1", want.found_kind1, got.found_kind1);
            check_field("found_kind2", 64'(want.found_kind2), 64'(got.found_kind2));
            check_field("found_amount", 64'(want.found_amount), 64'(got.found_amount));
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import klirs_pkg::*;
    import klirs_tb_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1600;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    // The longest operation is a remove from a full list; the closing wait allows
    // rather more than that takes.
    localparam int         DRAIN_CYCLES = 100;
    localparam int         POOL_SIZE    = 24;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_cmd   = '0;
    logic        o_valid;
    t_rsp        o_res;

    list_shadow   sb;
    logic [231:0] name_pool[POOL_SIZE];
    int unsigned  cycle_count = 0;
    // The random part alternates between filling the list and draining it, so that
    // both the full and the empty list are reached many times over.
    bit           filling = 1'b1;

    keyed_list_insert_remove_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A result is on the ports for exactly one cycle, and the transfer takes place at
    // the rising edge that closes it. Values are read here before that edge's updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_res);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [255:0] rand_wide();
        logic [255:0] v;
        for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // Name as the block sees it: first character in the low byte, zero padded.
    function automatic logic [231:0] text_name(string s);
        logic [231:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 29; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    // Half of the fresh names are raw bit patterns over all 29 bytes, the rest
    // printable text of random length.
    function automatic logic [231:0] fresh_name();
        logic [255:0] w;
        logic [231:0] v;
        int           n;
        w = rand_wide();
        v = '0;
        if ($urandom_range(0, 1) == 0) return w[231:0];
        n = $urandom_range(1, 29);
        for (int i = 0; i < n; i++) v[8*i +: 8] = 8'($urandom_range(33, 126));
        return v;
    endfunction

    function automatic logic [151:0] random_kind();
        logic [255:0] w;
        w = rand_wide();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return w[151:0];
        endcase
    endfunction

    // Mostly good quantities, with zero, negative and the extremes mixed in.
    function automatic logic [31:0] random_qty();
        case ($urandom_range(0, 19))
            0:             return 32'd0;
            1:             return 32'h7FFF_FFFF;
            2:             return 32'h8000_0000;
            3, 4, 5:       return $urandom;
            6, 7, 8, 9:    return $urandom_range(1, 100);
            default:       return $urandom_range(1, 32'h7FFF_FFFF);
        endcase
    endfunction

    function automatic t_req make_cmd(logic [1:0] act, logic [231:0] name,
                                      logic [151:0] kind, logic [31:0] qty);
        t_req c;
        c.action     = act;
        c.name_word0 = name[63:0];
        c.name_word1 = name[127:64];
        c.name_word2 = name[191:128];
        c.name_word3 = name[231:192];
        c.kind_word0 = kind[63:0];
        c.kind_word1 = kind[127:64];
        c.kind_word2 = kind[151:128];
        c.amount     = qty;
        return c;
    endfunction

    // Keys for remove and search: mostly names that are held, some that miss by a
    // single bit, and some from the pool or quite new.
    function automatic logic [231:0] lookup_name();
        logic [231:0] name;
        int           r;
        r = $urandom_range(0, 99);
        if (sb.held_count > 0 && r < 75) begin
            name = sb.held[$urandom_range(0, sb.held_count - 1)].key;
            if (r >= 60) name[$urandom_range(0, 231)] ^= 1'b1;
            return name;
        end
        if (r < 90) return name_pool[$urandom_range(0, POOL_SIZE - 1)];
        return fresh_name();
    endfunction

    function automatic t_req random_cmd();
        logic [1:0]   act;
        logic [231:0] name;
        int           r;
        if (filling && sb.held_count >= SHADOW_CAP) filling = 1'b0;
        else if (!filling && sb.held_count == 0) filling = 1'b1;
        else if ($urandom_range(0, 149) == 0) filling = !filling;
        r = $urandom_range(0, 99);
        if (r < 5) act = ACT_UNUSED;
        else if (r < (filling ? 60 : 25)) act = ACT_INSERT;
        else if (r < (filling ? 80 : 65)) act = ACT_REMOVE;
        else act = ACT_SEARCH;
        // The pool gives duplicate names on insert, so first-match rules get exercised.
        if (act == ACT_INSERT)
            name = ($urandom_range(0, 9) < 7) ? name_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : fresh_name();
        else
            name = lookup_name();
        return make_cmd(act, name, random_kind(), random_qty());
    endfunction

    // Presents one command and holds it until the block takes it. The transfer is
    // the rising edge at which start is high and busy is low.
    task automatic send_command(input t_req c);
        @(negedge i_clk);
        i_cmd <= c;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_command(c);
    endtask

    // Sender gap: start is low and the command lines carry noise the block must ignore.
    task automatic pause_sender(input int cycles);
        logic [511:0] w;
        repeat (cycles) begin
            @(negedge i_clk);
            w = {rand_wide(), rand_wide()};
            start <= 1'b0;
            i_cmd <= w[$bits(t_req)-1:0];
        end
    endtask

    initial begin
        logic [231:0] all_ones;
        int           burst;
        sb       = new();
        all_ones = '1;
        for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = fresh_name();
        // A pool pair that differs only in the top bit of the last name byte.
        name_pool[1] = name_pool[0] ^ {1'b1, 231'd0};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, sent back to back. First the empty list and refused inserts.
        send_command(make_cmd(ACT_SEARCH, text_name("alpha"), '0, 32'd1));
        send_command(make_cmd(ACT_REMOVE, text_name("alpha"), '0, 32'd1));
        send_command(make_cmd(ACT_UNUSED, all_ones, '1, '1));
        send_command(make_cmd(ACT_INSERT, text_name("alpha"), '1, 32'd0));
        send_command(make_cmd(ACT_INSERT, text_name("alpha"), '1, 32'hFFFF_FFFF));
        send_command(make_cmd(ACT_INSERT, text_name("alpha"), '1, 32'h8000_0000));
        // Extreme names, tags and quantities, then fill the list with one duplicate.
        send_command(make_cmd(ACT_INSERT, all_ones, '1, 32'h7FFF_FFFF));
        send_command(make_cmd(ACT_INSERT, '0, '0, 32'd1));
        for (int i = 2; i < SHADOW_CAP; i++)
            send_command(make_cmd(ACT_INSERT,
                                  (i == 9) ? all_ones : text_name($sformatf("item%0d", i)),
                                  random_kind(), 32'(i)));
        // A full list is refused even when the quantity is also bad.
        send_command(make_cmd(ACT_INSERT, text_name("alpha"), '0, 32'h8000_0000));
        send_command(make_cmd(ACT_SEARCH, all_ones, '0, 32'd0));
        send_command(make_cmd(ACT_REMOVE, all_ones, '0, 32'd0));
        send_command(make_cmd(ACT_SEARCH, all_ones, '0, 32'd0));
        send_command(make_cmd(ACT_SEARCH, '0, '0, 32'd0));
        send_command(make_cmd(ACT_SEARCH, all_ones ^ {1'b1, 231'd0}, '0, 32'd0));
        send_command(make_cmd(ACT_REMOVE, text_name("item15"), '0, 32'd0));
        send_command(make_cmd(ACT_UNUSED, '0, '0, 32'd0));

        // Random part in bursts. Gaps are mostly short, so that start rises at varied
        // points of an operation, with an occasional long one.
        burst = $urandom_range(1, 20);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_command(random_cmd());
            burst--;
            if (burst == 0) begin
                pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 6));
                burst = $urandom_range(1, 20);
            end
        end

        // Lower start straight after the last transfer so the command is not taken twice.
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
